>>> design/seven_segment_scan_display_unit_defines.svh
// Assertion macros used by the seven-segment display unit design file.
`ifndef SEVEN_SEGMENT_SCAN_DISPLAY_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_DISPLAY_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ssd_pkg.sv
// Package with the item kinds, digit codes and segment patterns of the display driver.
package ssd_pkg;

  typedef enum logic [1:0] {
    ACT_SET_VALUE = 2'd0,
    ACT_SCAN_TICK = 2'd1,
    ACT_SET_LAMP  = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  localparam logic [3:0] DASH_CODE = 4'd10;

  localparam int unsigned NUM_DIGITS = 4;

  // Active-low segment pattern for a digit code, decimal point kept off.
  function automatic logic [7:0] seg_pattern(input logic [3:0] code);
    logic [7:0] pat;
    case (code)
      4'd0:    pat = 8'hC0;
      4'd1:    pat = 8'hF9;
      4'd2:    pat = 8'hA4;
      4'd3:    pat = 8'hB0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hF8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      4'd10:   pat = 8'hBF;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

endpackage

>>> design/seven_segment_scan_display_unit.sv
// Top level of the multiplexed four-digit seven-segment display and lamp driver.

// This block drives four multiplexed seven-segment digits and four indicator
// lamps, all active low, and returns one item for every input item: the pin
// levels after that item. An item in_tuser selects the operation. A set-value
// item converts the signed value to four digit codes with leading zeros; a
// negative value shows a dash and the three digits of its magnitude, and a
// value above 9999 or below -999 shows four dashes. The pins show a new value
// only as the scan reaches each digit. A scan-tick item lights the next digit
// in the order 0 to 3 and wraps. A lamp item switches lamp 1 to 4 on for a
// nonzero value and off for zero; other lamp numbers and the unused operation
// code leave the pins as they are. The block takes one item per cycle while
// the output is not stalled: an input register feeds a single stage of logic, and
// the drive registers themselves form the result register. The input stage
// keeps taking items while a result waits, as long as its own slot is free.
module seven_segment_scan_display_unit
  import ssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // value [15:0], lamp_index [19:16], zero fill [23:20]
  input  logic [1:0]  in_tuser,   // action [1:0]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // segment_lines [7:0], digit_select [11:8], lamp_lines [15:12]
);

`include "seven_segment_scan_display_unit_defines.svh"

  // Input register.
  logic               in_valid_r;
  action_t            act_r;
  logic signed [15:0] value_r;
  logic [3:0]         lamp_idx_r;

  // Display state; the drive registers double as the result register.
  logic [3:0]         digit_codes_r [NUM_DIGITS];
  logic [3:0]         digit_codes_nxt [NUM_DIGITS];
  logic [1:0]         scan_pos_r;
  logic [7:0]         segment_drive_r;
  logic [3:0]         digit_drive_r;
  logic [3:0]         lamp_drive_r;
  logic               out_valid_r;

  logic               proc_fire;
  logic               in_fire;

  // Conversion signals.
  logic               out_of_range;
  logic               negative;
  logic [15:0]        mag16;
  logic [13:0]        mag;
  logic [29:0]        prod1000;
  logic [29:0]        prod100;
  logic [29:0]        prod10;
  logic [5:0]         q1000;
  logic [9:0]         q100;
  logic [10:0]        q10;
  logic [9:0]         d1_w;
  logic [10:0]        d2_w;
  logic [13:0]        d3_w;

  // The logic stage runs when it holds an item and the result slot is free or
  // being emptied in this cycle.
  assign proc_fire  = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || proc_fire;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {lamp_drive_r, digit_drive_r, segment_drive_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (proc_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r      <= action_t'(in_tuser);
      value_r    <= signed'(in_tdata[15:0]);
      lamp_idx_r <= in_tdata[19:16];
    end
  end

  // Binary to decimal. The three quotients come from reciprocal multiplies
  // that are exact for any 14-bit magnitude; each digit is then a quotient
  // minus ten times the next coarser one.
  always_comb begin
    out_of_range = (value_r > 16'sd9999) || (value_r < -16'sd999);
    negative     = value_r[15];
    mag16        = negative ? 16'(-value_r) : 16'(value_r);
    mag          = mag16[13:0];
    prod1000     = {16'd0, mag} * 30'd16778;
    prod100      = {16'd0, mag} * 30'd10486;
    prod10       = {16'd0, mag} * 30'd52429;
    q1000        = prod1000[29:24];
    q100         = prod100[29:20];
    q10          = prod10[29:19];
    d1_w         = q100 - 10'(q1000) * 10'd10;
    d2_w         = q10 - 11'(q100) * 11'd10;
    d3_w         = mag - 14'(q10) * 14'd10;

    if (out_of_range) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_codes_nxt[i] = DASH_CODE;
      end
    end else begin
      digit_codes_nxt[0] = negative ? DASH_CODE : q1000[3:0];
      digit_codes_nxt[1] = d1_w[3:0];
      digit_codes_nxt[2] = d2_w[3:0];
      digit_codes_nxt[3] = d3_w[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_codes_r[i] <= 4'd0;
      end
      scan_pos_r      <= 2'd0;
      segment_drive_r <= 8'hFF;
      digit_drive_r   <= 4'hF;
      lamp_drive_r    <= 4'hF;
    end else if (proc_fire) begin
      case (act_r)
        ACT_SET_VALUE: begin
          digit_codes_r <= digit_codes_nxt;
        end
        ACT_SCAN_TICK: begin
          segment_drive_r <= seg_pattern(digit_codes_r[scan_pos_r]);
          digit_drive_r   <= ~(4'b0001 << scan_pos_r);
          scan_pos_r      <= scan_pos_r + 2'd1;
        end
        ACT_SET_LAMP: begin
          if (lamp_idx_r inside {[4'd1:4'd4]}) begin
            lamp_drive_r[2'(lamp_idx_r - 4'd1)] <= (value_r == 16'sd0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // At most one digit is ever enabled.
  `SSD_ASSERT_NOW(a_one_digit, 1'b1, (digit_drive_r == 4'hF) || ($countones(digit_drive_r) == 3), "more than one digit enabled")
  // A scan tick advances the scan position by one.
  `SSD_ASSERT_NEXT(a_scan_adv, proc_fire && (act_r == ACT_SCAN_TICK), scan_pos_r == $past(scan_pos_r) + 2'd1, "scan position did not advance")
  // Only a scan tick moves the segment and digit pins.
  `SSD_ASSERT_NEXT(a_pins_hold, proc_fire && (act_r != ACT_SCAN_TICK), $stable(segment_drive_r) && $stable(digit_drive_r), "pins changed without a scan tick")
  // Every processed item leaves a result behind.
  `SSD_ASSERT_NEXT(a_result, proc_fire, out_valid_r, "processed item produced no result")

endmodule
